// ===== rtl/core/swm_pkg.sv =====
`timescale 1ns / 1ps
// Shared definitions for the sliding-window median filter.
// Holds default sizes, register codes and the sorter control struct; depends on nothing.
package swm_pkg;

  localparam int MAX_WINDOW_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int                    WINDOW_LEN_W     = 6;
  localparam logic [WINDOW_LEN_W-1:0] WINDOW_LEN_RESET = 6'd3;

  localparam int   PADDR_W        = 3;
  localparam int   PDATA_W        = 32;
  localparam logic REG_WINDOW_LEN = 1'b0;

  typedef struct packed {
    logic update;
    logic remove;
  } swm_ctrl_t;

endpackage

// ===== rtl/core/swm_cell.sv =====
`timescale 1ns / 1ps
// One cell of the sorted row: holds one window value in ascending position.
// Depends on swm_pkg for the control struct.
module swm_cell #(
  parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
  parameter int INDEX       = 0
) (
  input  logic                          clk,
  input  swm_pkg::swm_ctrl_t            ctrl,
  input  logic signed [SAMPLE_BITS-1:0] samp,
  input  logic signed [SAMPLE_BITS-1:0] old,
  input  logic [$clog2(MAX_WINDOW+1)-1:0] count,
  input  logic signed [SAMPLE_BITS-1:0] left_r,
  input  logic                          left_gt,
  input  logic signed [SAMPLE_BITS-1:0] right_val,
  output logic signed [SAMPLE_BITS-1:0] val,
  output logic signed [SAMPLE_BITS-1:0] r_val,
  output logic                          r_gt
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);

  logic                          lt;
  logic                          in_range;
  logic                          at_end;
  logic signed [SAMPLE_BITS-1:0] val_next;

  // With the oldest value taken out, cells from its position on close up from the right.
  assign lt       = val < old;
  assign r_val    = (!ctrl.remove || lt) ? val : right_val;
  assign in_range = CNT_W'(INDEX) < count;
  assign r_gt     = in_range && (r_val > samp);
  assign at_end   = count == CNT_W'(INDEX);

  always_comb begin
    if (left_gt) begin
      val_next = left_r;
    end else if (r_gt || at_end) begin
      val_next = samp;
    end else begin
      val_next = r_val;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.update) begin
      val <= val_next;
    end
  end

endmodule

// ===== rtl/core/swm_sorter.sv =====
`timescale 1ns / 1ps
// Row of sorting cells, each linked to its left and right neighbours where they exist.
// Depends on swm_pkg and swm_cell.
module swm_sorter #(
  parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                    clk,
  input  swm_pkg::swm_ctrl_t                      ctrl,
  input  logic signed [SAMPLE_BITS-1:0]           samp,
  input  logic signed [SAMPLE_BITS-1:0]           old,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]         count,
  output logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0]  cell_vals
);

  logic signed [SAMPLE_BITS-1:0] vals  [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] r_vals[MAX_WINDOW];
  logic                          r_gts [MAX_WINDOW];

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] left_r;
    logic                          left_gt;
    logic signed [SAMPLE_BITS-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_r  = samp;
      assign left_gt = 1'b0;
    end else begin : g_mid
      assign left_r  = r_vals[i-1];
      assign left_gt = r_gts[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign right_val = vals[i];
    end else begin : g_inner
      assign right_val = vals[i+1];
    end

    swm_cell #(
      .MAX_WINDOW (MAX_WINDOW),
      .SAMPLE_BITS(SAMPLE_BITS),
      .INDEX      (i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .samp     (samp),
      .old      (old),
      .count    (count),
      .left_r   (left_r),
      .left_gt  (left_gt),
      .right_val(right_val),
      .val      (vals[i]),
      .r_val    (r_vals[i]),
      .r_gt     (r_gts[i])
    );

    assign cell_vals[i] = vals[i];
  end

endmodule

// ===== rtl/core/sliding_window_median.sv =====
`timescale 1ns / 1ps
// Top level of the sliding-window median filter: ring store, control and result register.
// Depends on swm_pkg and swm_sorter.
//
// Each sample passes through three steps: the oldest sample is read out of the arrival
// ring, the row of sorting cells drops that sample and places the new one, and the median
// is picked and the result register loaded. sample_stall is high during the last two steps,
// and when the sample gives a result it stays high for as long as an earlier result is still
// held by median_stall, because the result register cannot be loaded until that transfer is done.
// No result is given until window_len samples have arrived; from then on each
// sample gives one result, twice the median, with one fraction bit for even windows.
// A window_len of zero acts as one and values above MAX_WINDOW act as MAX_WINDOW.
// Writing window_len empties the window; it is to be written only while the block is idle (not enforced by the block).
module sliding_window_median #(
  parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [swm_pkg::PADDR_W-1:0]       paddr,
  input  logic [swm_pkg::PDATA_W-1:0]       pwdata,
  output logic [swm_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  output logic                              median_valid,
  input  logic                              median_stall,
  output logic signed [SAMPLE_BITS:0]       median_x2
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WL_W  = swm_pkg::WINDOW_LEN_W;
  localparam int CMP_W = (CNT_W > WL_W) ? CNT_W : WL_W;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_UPDATE = 3'b010,
    S_MEDIAN = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [WL_W-1:0]               window_len;
  logic [CNT_W-1:0]              fill_count;
  logic [IDX_W-1:0]              oldest_pointer;
  logic [CNT_W-1:0]              len;
  logic                          filling;
  logic [IDX_W-1:0]              ptr_wrapped;
  logic [IDX_W-1:0]              ptr_inc;
  logic [IDX_W-1:0]              wr_addr;
  logic                          accept;
  logic                          cfg_write;

  logic signed [SAMPLE_BITS-1:0] arrival_ring[MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] old_q;
  logic signed [SAMPLE_BITS-1:0] samp_q;
  logic                          remove_q;
  logic                          emit_q;
  logic [CNT_W-1:0]              count_q;

  swm_pkg::swm_ctrl_t                      ctrl;
  logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0]  cell_vals;
  logic [IDX_W-1:0]                        hi_idx;
  logic [IDX_W-1:0]                        lo_idx;
  logic signed [SAMPLE_BITS-1:0]           mid_a;
  logic signed [SAMPLE_BITS-1:0]           mid_b;
  logic signed [SAMPLE_BITS:0]             mid_sum;
  logic                                    load_out;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == swm_pkg::REG_WINDOW_LEN);
  assign prdata    = (paddr[2] == swm_pkg::REG_WINDOW_LEN) ?
                     swm_pkg::PDATA_W'(window_len) : '0;

  always_comb begin
    if (window_len == '0) begin
      len = CNT_W'(1);
    end else if (CMP_W'(window_len) > CMP_W'(MAX_WINDOW)) begin
      len = CNT_W'(MAX_WINDOW);
    end else begin
      len = CNT_W'(window_len);
    end
  end

  assign filling      = fill_count < len;
  assign ptr_wrapped  = (CNT_W'(oldest_pointer) >= len) ? '0 : oldest_pointer;
  assign ptr_inc      = (CNT_W'(ptr_wrapped) + CNT_W'(1) >= len) ? '0 : ptr_wrapped + 1'b1;
  assign wr_addr      = filling ? fill_count[IDX_W-1:0] : ptr_wrapped;
  assign sample_stall = state != S_IDLE;
  assign accept       = sample_valid && (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len     <= swm_pkg::WINDOW_LEN_RESET;
      fill_count     <= '0;
      oldest_pointer <= '0;
    end else if (cfg_write) begin
      window_len     <= pwdata[WL_W-1:0];
      fill_count     <= '0;
      oldest_pointer <= '0;
    end else if (accept) begin
      if (filling) begin
        fill_count <= fill_count + 1'b1;
      end else begin
        oldest_pointer <= ptr_inc;
      end
    end
  end

  // The ring read returns the entry as it was before this transfer overwrites it.
  always_ff @(posedge clk) begin
    if (accept) begin
      arrival_ring[wr_addr] <= sample;
      old_q                 <= arrival_ring[wr_addr];
      samp_q                <= sample;
      remove_q              <= !filling;
      count_q               <= filling ? fill_count : len - 1'b1;
      emit_q                <= !filling || (fill_count + 1'b1 == len);
    end
  end

  assign ctrl.update = state == S_UPDATE;
  assign ctrl.remove = remove_q;

  swm_sorter #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_sorter (
    .clk      (clk),
    .ctrl     (ctrl),
    .samp     (samp_q),
    .old      (old_q),
    .count    (count_q),
    .cell_vals(cell_vals)
  );

  assign hi_idx  = IDX_W'(len >> 1);
  assign lo_idx  = len[0] ? hi_idx : hi_idx - 1'b1;
  assign mid_a   = $signed(cell_vals[lo_idx]);
  assign mid_b   = $signed(cell_vals[hi_idx]);
  assign mid_sum = {mid_a[SAMPLE_BITS-1], mid_a} + {mid_b[SAMPLE_BITS-1], mid_b};

  assign load_out = (state == S_MEDIAN) && emit_q && !(median_valid && median_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (sample_valid) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_next = S_MEDIAN;
      end
      S_MEDIAN: begin
        if (!emit_q || load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      median_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        median_valid <= 1'b1;
      end else if (!median_stall) begin
        median_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      median_x2 <= mid_sum;
    end
  end

endmodule
